// File: hdl/dwrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Daily window relay scheduler package
// Shared constants, codes, handshake structs and window helpers.
// ----------------------------------------------------------------------------
package dwrs_pkg;

  localparam int RELAYS      = 4;
  localparam int SLOTS       = 4;
  localparam int RIDX_W      = 2;
  localparam int SIDX_W      = 2;
  localparam int MIN_W       = 11;
  localparam int PINS_W      = 4;
  localparam int MAX_RESULTS = 4;
  localparam int EMIT_W      = $clog2(MAX_RESULTS);

  localparam logic [MIN_W-1:0] MINUTE_MAX = MIN_W'(1439);

  localparam logic CAUSE_MANUAL = 1'b0;
  localparam logic CAUSE_TICK   = 1'b1;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_MANUAL = 2'd1,
    OP_SLOT   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_EMIT,
    ST_MANUAL
  } state_t;

  typedef struct packed {
    logic latch;
    logic slot_wr;
    logic eval_step;
    logic emit_load;
    logic manual_load;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic eval_done;
    logic emit_last;
  } dp_status_t;

  function automatic logic [MIN_W-1:0] sat_minute(input logic [MIN_W-1:0] m);
    sat_minute = (m > MINUTE_MAX) ? MINUTE_MAX : m;
  endfunction

  function automatic logic window_hit(input logic [MIN_W-1:0] on_m,
                                      input logic [MIN_W-1:0] off_m,
                                      input logic [MIN_W-1:0] m);
    if (on_m <= off_m) begin
      window_hit = (m >= on_m) && (m < off_m);
    end else begin
      window_hit = (m >= on_m) || (m < off_m);
    end
  endfunction

endpackage

// File: hdl/dwrs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Daily window relay scheduler controller
// Sequences item intake, relay evaluation and result emission.
// ----------------------------------------------------------------------------
module dwrs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [1:0]           op,
  input  logic                 clock_valid,
  input  dwrs_pkg::dp_status_t status,
  output logic                 in_ready,
  output dwrs_pkg::dp_cmd_t    cmd
);
  import dwrs_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (op == OP_TICK) begin
            state_next = clock_valid ? ST_EVAL : ST_EMIT;
          end else if (op == OP_MANUAL) begin
            state_next = ST_MANUAL;
          end
        end
      end
      ST_EVAL: begin
        if (status.eval_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free && status.emit_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_MANUAL: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = 1'b0;
    cmd             = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.latch     = in_valid;
        cmd.slot_wr   = in_valid && (op == OP_SLOT);
      end
      ST_EVAL: begin
        cmd.eval_step = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit_load = status.out_free;
      end
      ST_MANUAL: begin
        cmd.manual_load = status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVAL && !status.eval_done) |=> (state == ST_EVAL))
    else $error("Evaluation left before the last relay.");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_MANUAL && status.out_free) |=> (state == ST_IDLE))
    else $error("Manual result was not completed in one load.");

  assert property (@(posedge clk) disable iff (rst)
    (in_ready && in_valid && op == OP_SLOT) |=> (state == ST_IDLE))
    else $error("Slot write did not return to idle.");

endmodule

// File: hdl/dwrs_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Daily window relay scheduler datapath
// Slot table, relay states, window evaluation and the output register.
// ----------------------------------------------------------------------------
module dwrs_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  dwrs_pkg::dp_cmd_t               cmd,
  output dwrs_pkg::dp_status_t            status,
  input  logic                            cfg_we,
  input  logic                            cfg_data,
  input  logic [dwrs_pkg::MIN_W-1:0]      minute_of_day,
  input  logic [dwrs_pkg::RIDX_W-1:0]     relay_index,
  input  logic                            manual_on,
  input  logic [dwrs_pkg::SIDX_W-1:0]     slot_index,
  input  logic                            slot_enabled,
  input  logic [dwrs_pkg::MIN_W-1:0]      slot_on_minute,
  input  logic [dwrs_pkg::MIN_W-1:0]      slot_off_minute,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            changed,
  output logic [dwrs_pkg::RIDX_W-1:0]     event_relay,
  output logic                            relay_now_on,
  output logic                            cause,
  output logic [dwrs_pkg::PINS_W-1:0]     pin_levels,
  output logic                            last
);
  import dwrs_pkg::*;

  logic                    slot_en  [RELAYS][SLOTS];
  logic [MIN_W-1:0]        slot_on  [RELAYS][SLOTS];
  logic [MIN_W-1:0]        slot_off [RELAYS][SLOTS];
  logic [RELAYS-1:0]       relay_states;
  logic [RELAYS-1:0]       relay_states_next;
  logic                    active_low;
  logic [MIN_W-1:0]        minute_q;
  logic [RIDX_W-1:0]       ri_q;
  logic                    mon_q;
  logic [RIDX_W-1:0]       eval_cnt;
  logic [RELAYS-1:0]       chg_mask;
  logic [RELAYS-1:0]       mask_rest;
  logic [RIDX_W-1:0]       low_idx;
  logic [EMIT_W-1:0]       emit_cnt;
  logic [SLOTS-1:0]        hits;
  logic                    want;
  logic                    ri_ok;
  logic                    wr_ok;
  logic                    out_free;

  assign out_free = !out_valid || out_ready;
  assign ri_ok    = int'(ri_q) < RELAYS;
  assign wr_ok    = (int'(relay_index) < RELAYS) && (int'(slot_index) < SLOTS);

  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      hits[s] = slot_en[eval_cnt][s] &&
                window_hit(slot_on[eval_cnt][s], slot_off[eval_cnt][s], minute_q);
    end
  end
  assign want = |hits;

  always_comb begin
    low_idx   = '0;
    mask_rest = chg_mask;
    for (int i = RELAYS - 1; i >= 0; i--) begin
      if (chg_mask[i]) begin
        low_idx = RIDX_W'(i);
      end
    end
    mask_rest[low_idx] = 1'b0;
  end

  always_comb begin
    relay_states_next = relay_states;
    if (cmd.manual_load && ri_ok) begin
      relay_states_next[ri_q] = mon_q;
    end else if (cmd.eval_step) begin
      relay_states_next[eval_cnt] = want;
    end
  end

  assign status.out_free  = out_free;
  assign status.eval_done = (eval_cnt == RIDX_W'(RELAYS - 1));
  assign status.emit_last = (chg_mask == '0) || (mask_rest == '0) ||
                            (emit_cnt == EMIT_W'(MAX_RESULTS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      active_low   <= 1'b0;
      relay_states <= '0;
      for (int r = 0; r < RELAYS; r++) begin
        for (int s = 0; s < SLOTS; s++) begin
          slot_en[r][s]  <= 1'b0;
          slot_on[r][s]  <= '0;
          slot_off[r][s] <= '0;
        end
      end
    end else begin
      relay_states <= relay_states_next;
      if (cfg_we) begin
        active_low <= cfg_data;
      end
      if (cmd.slot_wr && wr_ok) begin
        slot_en[relay_index][slot_index]  <= slot_enabled;
        slot_on[relay_index][slot_index]  <= sat_minute(slot_on_minute);
        slot_off[relay_index][slot_index] <= sat_minute(slot_off_minute);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eval_cnt <= '0;
      chg_mask <= '0;
      emit_cnt <= '0;
    end else if (cmd.latch) begin
      eval_cnt <= '0;
      chg_mask <= '0;
      emit_cnt <= '0;
    end else if (cmd.eval_step) begin
      eval_cnt <= eval_cnt + 1'b1;
      chg_mask[eval_cnt] <= (want != relay_states[eval_cnt]);
    end else if (cmd.emit_load) begin
      chg_mask <= mask_rest;
      emit_cnt <= emit_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      minute_q <= minute_of_day;
      ri_q     <= relay_index;
      mon_q    <= manual_on;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_load || cmd.manual_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load || cmd.manual_load) begin
      pin_levels <= relay_states_next ^ {PINS_W{active_low}};
    end
    if (cmd.manual_load) begin
      changed      <= ri_ok && (relay_states[ri_q] != mon_q);
      event_relay  <= ri_q;
      relay_now_on <= ri_ok && mon_q;
      cause        <= CAUSE_MANUAL;
      last         <= 1'b1;
    end else if (cmd.emit_load) begin
      cause <= CAUSE_TICK;
      if (chg_mask == '0) begin
        changed      <= 1'b0;
        event_relay  <= '0;
        relay_now_on <= 1'b0;
        last         <= 1'b1;
      end else begin
        changed      <= 1'b1;
        event_relay  <= low_idx;
        relay_now_on <= relay_states[low_idx];
        last         <= (mask_rest == '0) || (emit_cnt == EMIT_W'(MAX_RESULTS - 1));
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && cause == CAUSE_TICK && !changed) |-> last)
    else $error("A tick no-change result must be the final item.");

  assert property (@(posedge clk) disable iff (rst)
    (cmd.manual_load || cmd.emit_load) |-> out_free)
    else $error("Output register loaded while a result still waits.");

  assert property (@(posedge clk) disable iff (rst)
    (cmd.manual_load) |=> (out_valid && cause == CAUSE_MANUAL && last))
    else $error("Manual result not presented after load.");

  assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_load && chg_mask != '0) |=>
      (changed && relay_states[event_relay] == relay_now_on))
    else $error("Tick result disagrees with the relay state.");

endmodule

// File: hdl/daily_window_relay_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Daily window relay scheduler
// Four relays with four daily on/off windows each, manual override and pin polarity.
// A manual set loads its result once the output is free. A tick evaluates each relay in
// turn, then emits one result per changed relay, one per cycle while taken, or a single
// no-change result if none changed or the clock is not valid; slot writes stay idle. New
// items wait meanwhile. Reset turns relays off, clears slots and polarity.
// ----------------------------------------------------------------------------
module daily_window_relay_scheduler (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic                            cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      op,
  input  logic [dwrs_pkg::MIN_W-1:0]      minute_of_day,
  input  logic                            clock_valid,
  input  logic [dwrs_pkg::RIDX_W-1:0]     relay_index,
  input  logic                            manual_on,
  input  logic [dwrs_pkg::SIDX_W-1:0]     slot_index,
  input  logic                            slot_enabled,
  input  logic [dwrs_pkg::MIN_W-1:0]      slot_on_minute,
  input  logic [dwrs_pkg::MIN_W-1:0]      slot_off_minute,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            changed,
  output logic [dwrs_pkg::RIDX_W-1:0]     event_relay,
  output logic                            relay_now_on,
  output logic                            cause,
  output logic [dwrs_pkg::PINS_W-1:0]     pin_levels,
  output logic                            last
);
  import dwrs_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  dwrs_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .op          (op),
    .clock_valid (clock_valid),
    .status      (status),
    .in_ready    (in_ready),
    .cmd         (cmd)
  );

  dwrs_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .minute_of_day   (minute_of_day),
    .relay_index     (relay_index),
    .manual_on       (manual_on),
    .slot_index      (slot_index),
    .slot_enabled    (slot_enabled),
    .slot_on_minute  (slot_on_minute),
    .slot_off_minute (slot_off_minute),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .changed         (changed),
    .event_relay     (event_relay),
    .relay_now_on    (relay_now_on),
    .cause           (cause),
    .pin_levels      (pin_levels),
    .last            (last)
  );

endmodule
